/* rtl/ctq_pkg.sv */
// Shared types, register codes and reset values for the capacitive touch qualifier.
package ctq_pkg;

  localparam int unsigned PinW    = 6;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned RegIdxW = 2;

  typedef enum logic [RegIdxW-1:0] {
    RegEnable         = 2'd0,
    RegSensedPin      = 2'd1,
    RegTouchThreshold = 2'd2,
    RegReleaseHoldoff = 2'd3
  } ctq_reg_e;

  localparam logic             EnableRst    = 1'b0;
  localparam logic [PinW-1:0]  SensedPinRst = 6'd22;
  localparam logic [TimeW-1:0] ThresholdRst = 32'd10000;
  localparam logic [TimeW-1:0] HoldoffRst   = 32'd2000000;

  typedef struct packed {
    logic             enable;
    logic [PinW-1:0]  sensed_pin;
    logic [TimeW-1:0] touch_threshold;
    logic [TimeW-1:0] release_holdoff;
  } ctq_cfg_t;

  typedef struct packed {
    logic [PinW-1:0]  pin;
    logic             level;
    logic [TimeW-1:0] timestamp;
  } ctq_evt_t;

endpackage

/* rtl/ctq_if.sv */
// Handshake interfaces for the edge event, result and configuration channels.
interface ctq_evt_if import ctq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PinW-1:0]  pin;
  logic             level;
  logic [TimeW-1:0] timestamp;

  modport source (output valid, pin, level, timestamp, input ready);
  modport sink   (input valid, pin, level, timestamp, output ready);
endinterface

interface ctq_res_if import ctq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] peak_charge_time;

  modport source (output valid, peak_charge_time, input ready);
  modport sink   (input valid, peak_charge_time, output ready);
endinterface

interface ctq_cfg_if import ctq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [TimeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ctq_cfg_regs.sv */
// Configuration register file of the capacitive touch qualifier.
module ctq_cfg_regs import ctq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctq_cfg_if.sink   cfg_i,
  output ctq_cfg_t  cfg_o
);

  ctq_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (ctq_reg_e'(cfg_i.index))
        RegEnable:         cfg_d.enable          = cfg_i.data[0];
        RegSensedPin:      cfg_d.sensed_pin      = cfg_i.data[PinW-1:0];
        RegTouchThreshold: cfg_d.touch_threshold = cfg_i.data;
        RegReleaseHoldoff: cfg_d.release_holdoff = cfg_i.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable          <= EnableRst;
      cfg_q.sensed_pin      <= SensedPinRst;
      cfg_q.touch_threshold <= ThresholdRst;
      cfg_q.release_holdoff <= HoldoffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/ctq_in_reg.sv */
// Input register that captures one edge event word.
module ctq_in_reg import ctq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctq_evt_if.sink   evt_i,
  input  logic      advance_i,
  output logic      valid_o,
  output ctq_evt_t  evt_o
);

  logic     valid_q, valid_d;
  ctq_evt_t evt_q, evt_d;
  logic     take;

  // take a new word when empty or when the held word moves on this cycle
  assign evt_i.ready = !valid_q || advance_i;
  assign take        = evt_i.valid && evt_i.ready;

  always_comb begin
    valid_d = valid_q;
    evt_d   = evt_q;
    if (take) begin
      valid_d         = 1'b1;
      evt_d.pin       = evt_i.pin;
      evt_d.level     = evt_i.level;
      evt_d.timestamp = evt_i.timestamp;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign valid_o = valid_q;
  assign evt_o   = evt_q;

endmodule

/* rtl/ctq_eval.sv */
// Edge qualification, charge time measurement and touch state tracking.
module ctq_eval import ctq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctq_cfg_t         cfg_i,
  input  logic             valid_i,
  input  ctq_evt_t         evt_i,
  input  logic             advance_i,
  output logic             emit_o,
  output logic [TimeW-1:0] peak_o
);

  logic             last_level_q, last_level_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             touched_q, touched_d;
  logic [TimeW-1:0] peak_q, peak_d;
  logic [TimeW-1:0] release_q, release_d;

  logic             hit;
  logic [TimeW-1:0] charge;
  logic             now_touched;
  logic [TimeW:0]   limit;
  logic             emit;

  // an event counts only when enabled, on the sensed pin and at a new level
  assign hit = valid_i && advance_i && cfg_i.enable &&
               (evt_i.pin == cfg_i.sensed_pin) && (evt_i.level != last_level_q);

  assign charge      = evt_i.timestamp - start_q;
  assign now_touched = charge > cfg_i.touch_threshold;
  assign limit       = {1'b0, release_q} + {1'b0, cfg_i.release_holdoff};

  always_comb begin
    last_level_d = last_level_q;
    start_d      = start_q;
    touched_d    = touched_q;
    peak_d       = peak_q;
    release_d    = release_q;
    emit         = 1'b0;
    if (hit) begin
      last_level_d = evt_i.level;
      if (!evt_i.level) begin
        start_d = evt_i.timestamp;
      end else if (start_q != '0) begin
        if (now_touched != touched_q) begin
          touched_d = now_touched;
          if (!now_touched) begin
            emit      = limit < {1'b0, evt_i.timestamp};
            release_d = evt_i.timestamp;
          end else begin
            peak_d = '0;
          end
        end
        // a new touch clears the peak, so a charge above threshold always wins
        if (now_touched && ((touched_q ? peak_q : '0) < charge)) begin
          peak_d = charge;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      start_q      <= '0;
      touched_q    <= 1'b0;
      peak_q       <= '0;
      release_q    <= '0;
    end else begin
      last_level_q <= last_level_d;
      start_q      <= start_d;
      touched_q    <= touched_d;
      peak_q       <= peak_d;
      release_q    <= release_d;
    end
  end

  assign emit_o = emit;
  assign peak_o = peak_q;

  a_emit_on_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ($past(touched_q) && !touched_q && (release_q == $past(evt_i.timestamp))))
    else $error("result emitted without a touch release");

  a_start_on_fall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(start_q) |-> $past(hit && !evt_i.level))
    else $error("start time changed outside a falling edge");

  a_level_on_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_level_q) |-> $past(hit))
    else $error("last level changed without a qualified edge");

  a_touch_needs_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(touched_q) || !$stable(release_q)) |-> $past(hit && evt_i.level && start_q != '0))
    else $error("touch state changed without a measured rising edge");

endmodule

/* rtl/ctq_out_reg.sv */
// Result register that holds one peak word until the receiver takes it.
module ctq_out_reg import ctq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [TimeW-1:0] peak_i,
  output logic             free_o,
  ctq_res_if.source        res_o
);

  logic             valid_q, valid_d;
  logic [TimeW-1:0] peak_q, peak_d;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    peak_d  = peak_q;
    if (load_i) begin
      valid_d = 1'b1;
      peak_d  = peak_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    peak_q <= peak_d;
  end

  assign res_o.valid            = valid_q;
  assign res_o.peak_charge_time = peak_q;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result word overwritten before it was taken");

endmodule

/* rtl/capacitive_touch_qualifier.sv */
// Top level of the capacitive touch qualifier.
//
// Usage:
//   evt_i  carries edge event words (pin, level, timestamp) from the sense pin.
//   res_o  carries one peak charge time word for each reported touch release.
//   cfg_i  writes the enable, sensed pin, touch threshold and release holdoff
//          registers by index; it is always ready and takes effect next cycle.
// Timing:
//   An event word is captured in the input register and evaluated against the
//   touch state once the output register is free; a result word is then loaded
//   into the output register, which drives res_o.valid.
//   One event word per cycle is accepted while results drain; the single
//   path from input register to output register sets that rate.
// Reset:
//   rst_ni clears both registers' valid flags and the touch state; the
//   configuration returns to disabled, pin 22, threshold 10000, holdoff 2000000.
// Stall:
//   When res_o.ready is low and a result is held, the input register holds its
//   word and evt_i.ready drops once that register is full; nothing is lost.
module capacitive_touch_qualifier import ctq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctq_evt_if.sink    evt_i,
  ctq_res_if.source  res_o,
  ctq_cfg_if.sink    cfg_i
);

  ctq_cfg_t         cfg;
  ctq_evt_t         evt;
  logic             evt_valid;
  logic             out_free;
  logic             advance;
  logic             emit;
  logic [TimeW-1:0] peak;

  // advance the held event only when the result register can take a word
  assign advance = evt_valid && out_free;

  ctq_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ctq_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt_i),
    .advance_i (advance),
    .valid_o   (evt_valid),
    .evt_o     (evt)
  );

  ctq_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (evt_valid),
    .evt_i     (evt),
    .advance_i (advance),
    .emit_o    (emit),
    .peak_o    (peak)
  );

  ctq_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (emit),
    .peak_i (peak),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

/* sim/capacitive_touch_qualifier_test.sv */
// Self-checking testbench for the capacitive touch qualifier: edge traffic, touch prediction.
module capacitive_touch_qualifier_test import ctq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 4;     // two-stage pipeline plus margin
  localparam int unsigned StallLimit  = 3000;  // cycles with no word moving on any channel
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off that backs up evt_i

  // Tracks the touch state of one sense pin and queues the peaks it will report.
  class touch_release_tracker;
    ctq_cfg_t         regs;
    logic             last_level;
    logic [TimeW-1:0] start_time;
    logic             touched;
    logic [TimeW-1:0] peak_charge;
    logic [TimeW-1:0] last_release;
    logic [TimeW-1:0] peaks_due[$];
    int unsigned      mismatches;

    function new();
      regs = '{enable: EnableRst, sensed_pin: SensedPinRst,
               touch_threshold: ThresholdRst, release_holdoff: HoldoffRst};
      last_level   = 1'b0;
      start_time   = '0;
      touched      = 1'b0;
      peak_charge  = '0;
      last_release = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(ctq_reg_e idx, logic [TimeW-1:0] data);
      case (idx)
        RegEnable:         regs.enable          = data[0];
        RegSensedPin:      regs.sensed_pin      = data[PinW-1:0];
        RegTouchThreshold: regs.touch_threshold = data;
        RegReleaseHoldoff: regs.release_holdoff = data;
        default: ;
      endcase
    endfunction

    function void apply_edge(ctq_evt_t ev);
      logic [TimeW-1:0] charge;
      logic             now_touched;
      logic [TimeW:0]   release_limit;
      if (ev.pin != regs.sensed_pin) return;
      if (ev.level == last_level || !regs.enable) return;
      last_level = ev.level;
      if (!ev.level) begin
        start_time = ev.timestamp;
        return;
      end
      if (start_time == '0) return;
      charge      = ev.timestamp - start_time;
      now_touched = (charge > regs.touch_threshold);
      if (now_touched != touched) begin
        touched = now_touched;
        if (!now_touched) begin
          release_limit = {1'b0, last_release} + {1'b0, regs.release_holdoff};
          if (release_limit < {1'b0, ev.timestamp}) peaks_due.push_back(peak_charge);
          last_release = ev.timestamp;
        end else begin
          peak_charge = '0;
        end
      end
      if (now_touched && peak_charge < charge) peak_charge = charge;
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task match_peak(logic [TimeW-1:0] got);
      logic [TimeW-1:0] want;
      if (peaks_due.size() == 0) begin
        flag_mismatch($sformatf("peak_charge_time %0d with no release pending", got));
      end else begin
        want = peaks_due.pop_front();
        if (got !== want)
          flag_mismatch($sformatf("peak_charge_time %0d, predicted %0d", got, want));
      end
    endtask

    function int unsigned pending();
      return peaks_due.size();
    endfunction
  endclass

  bit   clk;
  logic rst_n;

  ctq_evt_if evt_bus ();
  ctq_res_if res_bus ();
  ctq_cfg_if cfg_bus ();

  capacitive_touch_qualifier uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  touch_release_tracker sb = new();

  logic [TimeW-1:0] now_ts;        // running timer for well-formed charge cycles
  bit               send_steady;   // sender offers back to back while set
  int unsigned      hold_left;     // pending receiver hold-off, consumed by the ready driver
  int unsigned      stall_left;
  int unsigned      recv_span;
  bit               recv_steady;
  int unsigned      idle_cycles;

  initial begin
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive res_o.ready: a pressure hold-off wins, then random stalls, with steady stretches.
  always @(negedge clk) begin
    if (recv_span == 0) begin
      recv_steady = ($urandom_range(0, 3) == 0);
      recv_span   = $urandom_range(50, 300);
    end else begin
      recv_span--;
    end
    if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      res_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      res_bus.ready <= 1'b1;
      if (!recv_steady) stall_left = pick_gap();
    end
  end

  // Sample every channel at the rising edge; any moved word resets the stall counter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) sb.match_peak(res_bus.peak_charge_time);
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(ctq_reg_e'(cfg_bus.index), cfg_bus.data);
      if (evt_bus.valid && evt_bus.ready)
        sb.apply_edge('{pin: evt_bus.pin, level: evt_bus.level, timestamp: evt_bus.timestamp});
    end
    if ((res_bus.valid && res_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (evt_bus.valid && evt_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("FAIL capacitive_touch_qualifier");
    $finish;
  end

  // All driving tasks start and end right after a falling edge.
  task automatic send_event(logic [PinW-1:0] pin, logic level, logic [TimeW-1:0] ts,
                            int unsigned gap);
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_bus.valid     <= 1'b1;
    evt_bus.pin       <= pin;
    evt_bus.level     <= level;
    evt_bus.timestamp <= ts;
    do @(posedge clk); while (!evt_bus.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(ctq_reg_e idx, logic [TimeW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // Write all four registers back to back, then drop valid.
  task automatic apply_config(logic en, logic [PinW-1:0] pin, logic [TimeW-1:0] thr,
                              logic [TimeW-1:0] holdoff);
    write_reg(RegEnable, {{(TimeW-1){1'b0}}, en});
    write_reg(RegSensedPin, {{(TimeW-PinW){1'b0}}, pin});
    write_reg(RegTouchThreshold, thr);
    write_reg(RegReleaseHoldoff, holdoff);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted peak, then let the pipeline empty.
  task automatic wait_drained();
    evt_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic int unsigned pick_send_gap();
    return send_steady ? 0 : pick_gap();
  endfunction

  // Charge time on the chosen side of the threshold; hit the boundary now and then.
  function automatic logic [TimeW-1:0] pick_charge(bit want_touch);
    logic [TimeW-1:0] thr;
    thr = sb.regs.touch_threshold;
    if (want_touch && thr != '1) begin
      if ($urandom_range(0, 7) == 0) return thr + 1;
      if (thr > 32'hFFFF_0000) return $urandom_range(thr + 1, 32'hFFFF_FFFF);
      return thr + 1 + $urandom_range(0, 60000);
    end
    if (thr == '0 || $urandom_range(0, 7) == 0) return thr;
    if (thr < 60000) return $urandom_range(0, thr);
    return thr - $urandom_range(0, 60000);
  endfunction

  // Move the timer on: mostly short steps, some beyond a typical holdoff, rarely anywhere.
  task automatic advance_timer();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) now_ts += $urandom_range(0, 20000);
    else if (r < 95) now_ts += $urandom_range(0, 3000000);
    else now_ts = $urandom();
  endtask

  // Falling then rising edge on the sensed pin: one charge measurement.
  task automatic charge_cycle();
    logic [TimeW-1:0] t_fall;
    logic [TimeW-1:0] charge;
    advance_timer();
    t_fall = now_ts;
    charge = pick_charge(1'($urandom_range(0, 1)));
    send_event(sb.regs.sensed_pin, 1'b0, t_fall, pick_send_gap());
    send_event(sb.regs.sensed_pin, 1'b1, t_fall + charge, pick_send_gap());
    now_ts = t_fall + charge;
  endtask

  // Words the block should mostly ignore or that break the falling/rising pairing.
  task automatic noise_event();
    logic [PinW-1:0] offset;
    case ($urandom_range(0, 4))
      0: send_event(PinW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), $urandom(),
                    pick_send_gap());
      1: send_event(sb.regs.sensed_pin, sb.last_level, $urandom(), pick_send_gap());
      2: send_event(sb.regs.sensed_pin, 1'b0, '0, pick_send_gap());
      3: begin
        offset = PinW'($urandom_range(1, 63));
        send_event(sb.regs.sensed_pin + offset, 1'($urandom_range(0, 1)), now_ts,
                   pick_send_gap());
      end
      default: send_event(sb.regs.sensed_pin, 1'($urandom_range(0, 1)),
                          now_ts + $urandom_range(0, 30000), pick_send_gap());
    endcase
  endtask

  // Mostly well-formed charge cycles with random content, the rest noise.
  task automatic run_touch_traffic(int unsigned n_items, bit hold_steady);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if (!hold_steady && $urandom_range(0, 39) == 0) send_steady = ~send_steady;
      if ($urandom_range(0, 99) < 75) begin
        charge_cycle();
        sent += 2;
      end else begin
        noise_event();
        sent += 1;
      end
    end
  endtask

  // Short directed walk through the special cases at the reset configuration.
  task automatic run_directed();
    // disabled: both edges ignored, level not tracked
    send_event(6'd22, 1'b0, 32'd100, 0);
    send_event(6'd22, 1'b1, 32'd20000, 0);
    wait_drained();
    apply_config(1'b1, 6'd22, 32'd10000, 32'd2000000);
    send_event(6'd21, 1'b0, 32'd500, 0);               // other pin
    send_event(6'd22, 1'b1, 32'd5, 0);                 // rising with no start
    send_event(6'd22, 1'b1, 32'd9, 1);                 // unchanged level
    send_event(6'd22, 1'b0, 32'd0, 0);                 // start stamped zero
    send_event(6'd22, 1'b1, 32'd50000, 0);             // not measured
    send_event(6'd22, 1'b0, 32'd1000, 0);
    send_event(6'd22, 1'b1, 32'd21000, 2);             // touch
    send_event(6'd22, 1'b0, 32'd30000, 0);
    send_event(6'd22, 1'b1, 32'd30500, 0);             // release inside holdoff: suppressed
    send_event(6'd22, 1'b0, 32'd3000000, 0);
    send_event(6'd22, 1'b1, 32'd3010001, 0);           // touch, one above threshold
    send_event(6'd22, 1'b0, 32'd3100000, 3);
    send_event(6'd22, 1'b1, 32'd3150000, 0);           // larger peak
    send_event(6'd22, 1'b0, 32'd4000000, 0);
    send_event(6'd22, 1'b1, 32'd4010000, 0);           // exactly threshold: reported release
    send_event(6'd22, 1'b0, 32'hFFFF_FF00, 0);
    send_event(6'd22, 1'b1, 32'h0000_4000, 0);         // timer wrap during charge
    send_event(6'd22, 1'b0, 32'hFFFF_FFF0, 0);
    send_event(6'd22, 1'b1, 32'hFFFF_FFFF, 0);         // release at the top of the timer
    send_event(6'd63, 1'b1, 32'hFFFF_FFFF, 0);
    send_event(6'd0, 1'b0, 32'd0, 0);
    wait_drained();
  endtask

  initial begin
    evt_bus.valid     = 1'b0;
    evt_bus.pin       = '0;
    evt_bus.level     = 1'b0;
    evt_bus.timestamp = '0;
    res_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = RegEnable;
    cfg_bus.data      = '0;
    now_ts            = $urandom();
    send_steady       = 1'b0;
    hold_left         = 0;
    stall_left        = 0;
    recv_span         = 0;
    recv_steady       = 1'b0;
    idle_cycles       = 0;
    rst_n             = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();

    // Small holdoff; open with a long receiver hold-off while words keep coming.
    apply_config(1'b1, 6'd22, 32'd10000, 32'd5000);
    hold_left   = HoldCycles;
    send_steady = 1'b1;
    run_touch_traffic(120, 1'b1);
    send_steady = 1'b0;
    run_touch_traffic(180, 1'b0);
    wait_drained();

    // Lowest extremes: zero threshold and zero holdoff on pin 0.
    apply_config(1'b1, 6'd0, 32'd0, 32'd0);
    run_touch_traffic(250, 1'b0);
    wait_drained();

    // Highest extremes: nothing can count as touched, nothing reported.
    apply_config(1'b1, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_touch_traffic(150, 1'b0);
    wait_drained();

    // Disabled: every word dropped.
    apply_config(1'b0, 6'd63, 32'd10000, 32'd0);
    run_touch_traffic(50, 1'b0);
    wait_drained();

    // Random settings.
    repeat (4) begin
      apply_config(1'b1, PinW'($urandom_range(0, 63)), $urandom_range(0, 50000),
                   $urandom_range(0, 100000));
      run_touch_traffic(300, 1'b0);
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS capacitive_touch_qualifier");
    end else begin
      $display("FAIL capacitive_touch_qualifier");
    end
    $finish;
  end

endmodule
